// File: rtl/rtufr_pkg.sv
// Shared constants and types for the RTU reply frame receiver.
// No dependencies; imported by every module of the block.
package rtufr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned StatW = 2;

  localparam logic [CrcW-1:0]  CrcInit  = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly  = 16'hA001;
  localparam logic [ByteW-1:0] ExcBit   = 8'h80;
  localparam logic [PosW-1:0]  ShortLen = 9'd5;
  localparam logic [PosW-1:0]  WriteLen = 9'd8;
  localparam logic [PosW-1:0]  HdrLen   = 9'd3;
  localparam logic [ByteW-1:0] UnitRst  = 8'd1;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_WRONG_UNIT = 2'd1,
    STAT_CRC_ERROR = 2'd2,
    STAT_UNKNOWN_FN = 2'd3
  } status_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [PosW-1:0] total;
    logic [CrcW-1:0] crc;
    logic            unit_match;
  } frame_state_t;

endpackage

// File: rtl/rtu_reply_frame_receiver_unit.sv
// RTU reply frame receiver: framing, CRC-16 check and per-word echo.
// Depends on rtufr_pkg and rtufr_crc16_byte.
// An accepted word goes through the input register, then the result register,
// to result valid. Throughput: one word per cycle unless the output stalls,
// set by the combinational byte-wide CRC update and frame counter in decode.
// Reset: asynchronous, clears both stage valids and the frame state, with the
// CRC loaded with FFFF, and loads the expected unit with 1.
module rtu_reply_frame_receiver_unit
  import rtufr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             frame_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] data_byte_o,
  output logic             in_pdu_o,
  output logic             frame_end_o,
  output logic [StatW-1:0] status_o,
  output logic [PosW-1:0]  pdu_length_o
);

  logic [ByteW-1:0] unit_q;
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_start_q;
  frame_state_t     st_q, st_d;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_pdu_q, out_pdu_d;
  logic             out_end_q, out_end_d;
  status_e          out_stat_q, out_stat_d;
  logic [PosW-1:0]  out_len_q, out_len_d;

  logic             adv_out;
  logic             adv_in;
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  total;
  logic [CrcW-1:0]  crc_cur;
  logic [CrcW-1:0]  crc_nxt;
  logic [PosW-1:0]  total_n;
  logic [PosW:0]    pos_ext;

  assign adv_out    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv_out;
  assign adv_in     = in_valid_i && !in_stall_o;

  assign pos     = s1_start_q ? '0 : st_q.pos;
  assign total   = s1_start_q ? '0 : st_q.total;
  assign crc_cur = s1_start_q ? CrcInit : st_q.crc;
  assign pos_ext = {1'b0, pos};

  rtufr_crc16_byte u_crc (
    .crc_i  (crc_cur),
    .data_i (s1_byte_q),
    .crc_o  (crc_nxt)
  );

  assign total_n = (pos == 9'd2 && total == '0)
                 ? ({1'b0, s1_byte_q} + ShortLen) : total;

  always_comb begin
    st_d            = st_q;
    st_d.crc        = crc_nxt;
    out_pdu_d       = 1'b0;
    out_end_d       = 1'b0;
    out_stat_d      = STAT_OK;
    out_len_d       = '0;
    if (pos == '0) begin
      st_d.unit_match = (s1_byte_q == unit_q);
      st_d.total      = '0;
      st_d.pos        = 9'd1;
    end else if (pos == 9'd1) begin
      out_pdu_d = 1'b1;
      st_d.pos  = 9'd2;
      if ((s1_byte_q & ExcBit) != '0) begin
        st_d.total = ShortLen;
      end else if (s1_byte_q inside {[8'd1:8'd4]}) begin
        st_d.total = '0;
      end else if (s1_byte_q inside {8'd5, 8'd6, 8'd15, 8'd16}) begin
        st_d.total = WriteLen;
      end else begin
        out_end_d  = 1'b1;
        out_stat_d = STAT_UNKNOWN_FN;
        st_d.pos   = '0;
        st_d.total = '0;
        st_d.crc   = CrcInit;
      end
    end else begin
      st_d.total = total_n;
      out_pdu_d  = (pos_ext + 10'd2) < {1'b0, total_n};
      if ((pos_ext + 10'd1) >= {1'b0, total_n}) begin
        out_end_d = 1'b1;
        if (!st_q.unit_match) begin
          out_stat_d = STAT_WRONG_UNIT;
        end else if (crc_nxt != '0) begin
          out_stat_d = STAT_CRC_ERROR;
        end else begin
          out_stat_d = STAT_OK;
        end
        out_len_d  = total_n - HdrLen;
        st_d.pos   = '0;
        st_d.total = '0;
        st_d.crc   = CrcInit;
      end else begin
        st_d.pos = pos + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q      <= UnitRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{pos: '0, total: '0, crc: CrcInit, unit_match: 1'b0};
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_data_i;
      end
      if (adv_in) begin
        s1_valid_q <= 1'b1;
      end else if (adv_out) begin
        s1_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= frame_start_i;
    end
    if (adv_out) begin
      out_byte_q <= s1_byte_q;
      out_pdu_q  <= out_pdu_d;
      out_end_q  <= out_end_d;
      out_stat_q <= out_stat_d;
      out_len_q  <= out_len_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_byte_q;
  assign in_pdu_o     = out_pdu_q;
  assign frame_end_o  = out_end_q;
  assign status_o     = out_stat_q;
  assign pdu_length_o = out_len_q;

endmodule

// File: rtl/rtufr_crc16_byte.sv
// Byte-wide reflected CRC-16 update, polynomial taken from rtufr_pkg.
// Depends on rtufr_pkg.
module rtufr_crc16_byte
  import rtufr_pkg::*;
(
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] data_i,
  output logic [CrcW-1:0]  crc_o
);

  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {{(CrcW-ByteW){1'b0}}, data_i};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: rtl/rtufr_checker.sv
// Port-level checks for the RTU reply frame receiver, bound to the top level.
// Depends on rtufr_pkg and rtu_reply_frame_receiver_unit.
module rtufr_checker
  import rtufr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ByteW-1:0] data_byte_o,
  input logic             in_pdu_o,
  input logic             frame_end_o,
  input logic [StatW-1:0] status_o,
  input logic [PosW-1:0]  pdu_length_o
);

  a_stat_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> status_o == STAT_OK && pdu_length_o == '0)
    else $error("status or length outside frame end");

  a_unknown_fn_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && status_o == STAT_UNKNOWN_FN
      |-> in_pdu_o && pdu_length_o == '0)
    else $error("unknown function not on function word");

  a_end_is_crc_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && status_o != STAT_UNKNOWN_FN
      |-> !in_pdu_o && pdu_length_o >= 9'd2)
    else $error("frame end on a PDU word");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(frame_end_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind rtu_reply_frame_receiver_unit rtufr_checker u_rtufr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .data_byte_o  (data_byte_o),
  .in_pdu_o     (in_pdu_o),
  .frame_end_o  (frame_end_o),
  .status_o     (status_o),
  .pdu_length_o (pdu_length_o)
);
